// ===== hdl/rcppm_pkg.sv =====
// Shared constants for the RC PWM capture to PPM encoder.
// No dependencies; imported by the channel interfaces and the top level.
`default_nettype none

package rcppm_pkg;

   // field widths
   localparam int CMD_W   = 2;
   localparam int CH_W    = 3;
   localparam int WORD_W  = 32;
   localparam int CLK_W   = 27;
   localparam int FRAME_W = 17;
   localparam int START_W = 14;
   localparam int MASK_W  = 8;
   localparam int CSR_IDX_W = 3;

   localparam int NUM_CHANNELS_DEF = 8;

   // commands
   localparam logic [CMD_W-1:0] CMD_CAPTURE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SET     = 2'd1;
   localparam logic [CMD_W-1:0] CMD_PPM     = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_CLOCK_HZ     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CAPTURE_PER  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PWM_PER      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PPM_FRAME    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PPM_START    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_PASS_MASK    = 3'd5;

   // register reset values
   localparam logic [CLK_W-1:0]   RST_CLOCK_HZ    = 27'd80000000;
   localparam logic [WORD_W-1:0]  RST_CAPTURE_PER = 32'd4800000;
   localparam logic [WORD_W-1:0]  RST_PWM_PER     = 32'd1600000;
   localparam logic [FRAME_W-1:0] RST_PPM_FRAME   = 17'd22500;
   localparam logic [START_W-1:0] RST_PPM_START   = 14'd300;
   localparam logic [MASK_W-1:0]  RST_PASS_MASK   = 8'd255;

   // conversion constants
   localparam logic [CLK_W-1:0] US_PER_SEC = 27'd1000000;
   localparam logic [10:0] PWM_LOW_US    = 11'd1000;
   localparam logic [10:0] PWM_HIGH_US   = 11'd2000;
   localparam logic [10:0] PPM_LOW_US    = 11'd700;
   localparam logic [10:0] PPM_HIGH_US   = 11'd1700;
   localparam logic [10:0] PPM_OFFSET_US = 11'd300;

   // shared multiply/divide unit: product width and step counter width
   localparam int PROD_W = WORD_W + CLK_W;
   localparam int CNT_W  = $clog2(PROD_W);

endpackage

`default_nettype wire

// ===== hdl/rcppm_req_if.sv =====
// Request channel: valid/ready handshake with the input item fields.
// Depends on rcppm_pkg.
`default_nettype none

interface rcppm_req_if;
   import rcppm_pkg::*;

   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   command;
   logic [CH_W-1:0]    channel;
   logic [WORD_W-1:0]  timestamp;
   logic               pin_level;
   logic [WORD_W-1:0]  width_tics;

   modport source (output valid, command, channel, timestamp, pin_level, width_tics,
                   input ready);
   modport sink   (input valid, command, channel, timestamp, pin_level, width_tics,
                   output ready);
endinterface

`default_nettype wire

// ===== hdl/rcppm_rsp_if.sv =====
// Response channel: valid/ready handshake with the result item fields.
// Depends on rcppm_pkg.
`default_nettype none

interface rcppm_rsp_if;
   import rcppm_pkg::*;

   logic               valid;
   logic               ready;
   logic [WORD_W-1:0]  measured_width;
   logic               width_valid;
   logic [WORD_W-1:0]  match_value;
   logic               match_valid;
   logic [WORD_W-1:0]  ppm_interval_tics;
   logic               ppm_pin_level;

   modport source (output valid, measured_width, width_valid, match_value, match_valid,
                   ppm_interval_tics, ppm_pin_level, input ready);
   modport sink   (input valid, measured_width, width_valid, match_value, match_valid,
                   ppm_interval_tics, ppm_pin_level, output ready);
endinterface

`default_nettype wire

// ===== hdl/rc_pwm_capture_to_ppm_encoder.sv =====
// Top level of the RC PWM capture to PPM encoder.
// Depends on rcppm_pkg, rcppm_req_if and rcppm_rsp_if.
//
// Usage:
//  req  : one transfer per item (capture edge, software set or PPM timeout tick).
//  rsp  : exactly one transfer per accepted item, in order.
//  csr_*: write-only register port; write only while no item is in flight.
//  req.ready is high only while the sequencer is idle; one item is worked at a time.
//  States: a capture edge runs DIFF, then WRAP and MATCH where they apply, then
//  OUT; a software set runs MATCH then OUT; command 3 or an out-of-range channel
//  goes straight to OUT. PPM ticks run a shared bit-serial multiply/divide unit:
//  32 multiply steps plus 59 divide steps plus one post step per conversion.
//  A start pulse or the sync slot takes one conversion, a channel slot three.
//  The finished result sits in a staging register until the rsp output register
//  is free, so a stalled receiver holds the next item in the staging stage, which
//  keeps req.ready low. Data is never dropped.
//  Reset (synchronous, active high): registers take their defaults, all
//  output widths and seen flags clear, the PPM frame restarts with a start pulse
//  and the full frame time.
`default_nettype none

module rc_pwm_capture_to_ppm_encoder #(
   parameter int NUM_CHANNELS = rcppm_pkg::NUM_CHANNELS_DEF
) (
   input  wire                               clock,
   input  wire                               reset,
   rcppm_req_if.sink                         req,
   rcppm_rsp_if.source                       rsp,
   input  wire                               csr_we,
   input  wire [rcppm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire [rcppm_pkg::WORD_W-1:0]       csr_data
);
   import rcppm_pkg::*;

   localparam int IDX_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int SLOT_W = $clog2(NUM_CHANNELS + 1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_DIFF, ST_WRAP, ST_MATCH, ST_MUL, ST_DIV, ST_POST, ST_OUT
   } state_type;

   typedef enum logic [2:0] {
      STEP_START_T, STEP_SLOT_US, STEP_SLOT_T, STEP_SLOT_US2, STEP_SYNC_T
   } step_type;

   // configuration
   logic [CLK_W-1:0]   clock_hz_ff;
   logic [WORD_W-1:0]  capture_per_ff;
   logic [WORD_W-1:0]  pwm_per_ff;
   logic [FRAME_W-1:0] frame_us_ff;
   logic [START_W-1:0] start_us_ff;
   logic [MASK_W-1:0]  pass_mask_ff;

   // per-channel state
   logic [WORD_W-1:0]  last_stamp_ff [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0] seen_ff;
   logic [WORD_W-1:0]  out_width_ff  [NUM_CHANNELS];

   // PPM frame state
   logic               in_slot_ff;
   logic [SLOT_W-1:0]  slot_idx_ff;
   logic [FRAME_W-1:0] time_left_ff;

   // sequencer and latched item
   state_type          state_ff;
   step_type           step_ff;
   logic [CH_W-1:0]    ch_ff;
   logic [WORD_W-1:0]  now_ff;
   logic               level_ff;
   logic [WORD_W-1:0]  diff_ff;
   logic               lt_ff;
   logic [WORD_W-1:0]  w_ff;

   // staged result
   logic [WORD_W-1:0]  st_meas_ff;
   logic               st_wvalid_ff;
   logic [WORD_W-1:0]  st_match_ff;
   logic               st_mvalid_ff;
   logic [WORD_W-1:0]  st_ppm_t_ff;
   logic               st_pin_ff;

   // output register
   logic               rsp_valid_ff;
   logic [WORD_W-1:0]  rsp_meas_ff;
   logic               rsp_wvalid_ff;
   logic [WORD_W-1:0]  rsp_match_ff;
   logic               rsp_mvalid_ff;
   logic [WORD_W-1:0]  rsp_ppm_t_ff;
   logic               rsp_pin_ff;

   // bit-serial multiply/divide unit: q = sat32(a * b / d)
   logic [WORD_W-1:0]  mul_a_ff;
   logic [CLK_W-1:0]   mul_b_ff;
   logic [CLK_W-1:0]   div_d_ff;
   logic [PROD_W-1:0]  acc_ff;
   logic [CLK_W:0]     rem_ff;
   logic [WORD_W-1:0]  quo_ff;
   logic               ovf_ff;
   logic [CNT_W-1:0]   cnt_ff;

   logic [PROD_W-1:0]  acc_in;
   logic [CLK_W:0]     rem_shift;
   logic               qbit;
   logic [CLK_W:0]     rem_in;
   logic [WORD_W-1:0]  conv_res;
   logic [CLK_W-1:0]   clk_div;

   logic [IDX_W-1:0]   ch_idx;
   logic [IDX_W-1:0]   rd_idx;
   logic               ch_ok_req;
   logic               ch_ok;
   logic [WORD_W-1:0]  wrap_in;
   logic [WORD_W-1:0]  match_in;
   logic [10:0]        clamp_us;
   logic               out_free;

   assign clk_div = (clock_hz_ff == '0) ? CLK_W'(1) : clock_hz_ff;

   // one multiply step: shift the accumulator, add b on the current multiplier bit
   assign acc_in = {acc_ff[PROD_W-2:0], 1'b0} +
                   (mul_a_ff[WORD_W-1] ? PROD_W'(mul_b_ff) : '0);

   // one restoring divide step on the next product bit
   assign rem_shift = {rem_ff[CLK_W-1:0], acc_ff[PROD_W-1]};
   assign qbit      = (rem_shift >= {1'b0, div_d_ff});
   assign rem_in    = qbit ? (rem_shift - {1'b0, div_d_ff}) : rem_shift;
   assign conv_res  = ovf_ff ? '1 : quo_ff;

   assign ch_idx    = IDX_W'(ch_ff);
   assign rd_idx    = IDX_W'(NUM_CHANNELS - 1 - int'(slot_idx_ff));
   assign ch_ok_req = (int'(req.channel) < NUM_CHANNELS);
   assign ch_ok     = (int'(ch_ff) < NUM_CHANNELS);

   assign wrap_in = diff_ff + (lt_ff ? capture_per_ff : '0);

   // match count for width w_ff
   always_comb begin
      if (w_ff > pwm_per_ff) begin
         match_in = '0;
      end else if (w_ff == '0) begin
         match_in = (pwm_per_ff == '0) ? '0 : pwm_per_ff - WORD_W'(1);
      end else begin
         match_in = pwm_per_ff - w_ff;
      end
   end

   // map 1000..2000 us onto 700..1700 us
   always_comb begin
      if (conv_res < WORD_W'(PWM_LOW_US)) begin
         clamp_us = PPM_LOW_US;
      end else if (conv_res > WORD_W'(PWM_HIGH_US)) begin
         clamp_us = PPM_HIGH_US;
      end else begin
         clamp_us = conv_res[10:0] - PPM_OFFSET_US;
      end
   end

   assign out_free = !rsp_valid_ff || rsp.ready;

   assign req.ready             = (state_ff == ST_IDLE);
   assign rsp.valid             = rsp_valid_ff;
   assign rsp.measured_width    = rsp_meas_ff;
   assign rsp.width_valid       = rsp_wvalid_ff;
   assign rsp.match_value       = rsp_match_ff;
   assign rsp.match_valid       = rsp_mvalid_ff;
   assign rsp.ppm_interval_tics = rsp_ppm_t_ff;
   assign rsp.ppm_pin_level     = rsp_pin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_hz_ff    <= RST_CLOCK_HZ;
         capture_per_ff <= RST_CAPTURE_PER;
         pwm_per_ff     <= RST_PWM_PER;
         frame_us_ff    <= RST_PPM_FRAME;
         start_us_ff    <= RST_PPM_START;
         pass_mask_ff   <= RST_PASS_MASK;
         seen_ff        <= '0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            out_width_ff[i] <= '0;
         end
         in_slot_ff     <= 1'b0;
         slot_idx_ff    <= '0;
         time_left_ff   <= RST_PPM_FRAME;
         state_ff       <= ST_IDLE;
         step_ff        <= STEP_START_T;
         rsp_valid_ff   <= 1'b0;
      end else begin
         // configuration writes; indexes past the list are dropped
         if (csr_we) begin
            case (csr_index)
               REG_CLOCK_HZ:    clock_hz_ff    <= csr_data[CLK_W-1:0];
               REG_CAPTURE_PER: capture_per_ff <= csr_data;
               REG_PWM_PER:     pwm_per_ff     <= csr_data;
               REG_PPM_FRAME:   frame_us_ff    <= csr_data[FRAME_W-1:0];
               REG_PPM_START:   start_us_ff    <= csr_data[START_W-1:0];
               REG_PASS_MASK:   pass_mask_ff   <= csr_data[MASK_W-1:0];
               default: ;
            endcase
         end

         if (rsp_valid_ff && rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req.valid) begin
                  ch_ff        <= req.channel;
                  now_ff       <= req.timestamp;
                  level_ff     <= req.pin_level;
                  w_ff         <= req.width_tics;
                  st_meas_ff   <= '0;
                  st_wvalid_ff <= 1'b0;
                  st_match_ff  <= '0;
                  st_mvalid_ff <= 1'b0;
                  st_ppm_t_ff  <= '0;
                  st_pin_ff    <= 1'b0;
                  state_ff     <= ST_OUT;
                  if (req.command == CMD_CAPTURE && ch_ok_req) begin
                     state_ff <= ST_DIFF;
                  end else if (req.command == CMD_SET && ch_ok_req) begin
                     out_width_ff[IDX_W'(req.channel)] <= req.width_tics;
                     st_meas_ff   <= req.width_tics;
                     st_wvalid_ff <= 1'b1;
                     state_ff     <= ST_MATCH;
                  end else if (req.command == CMD_PPM) begin
                     // launch the first conversion of this tick
                     acc_ff   <= '0;
                     rem_ff   <= '0;
                     quo_ff   <= '0;
                     ovf_ff   <= 1'b0;
                     cnt_ff   <= CNT_W'(WORD_W - 1);
                     state_ff <= ST_MUL;
                     if (!in_slot_ff) begin
                        mul_a_ff <= WORD_W'(start_us_ff);
                        mul_b_ff <= clock_hz_ff;
                        div_d_ff <= US_PER_SEC;
                        step_ff  <= STEP_START_T;
                     end else if (int'(slot_idx_ff) < NUM_CHANNELS) begin
                        mul_a_ff <= out_width_ff[rd_idx];
                        mul_b_ff <= US_PER_SEC;
                        div_d_ff <= clk_div;
                        step_ff  <= STEP_SLOT_US;
                     end else begin
                        mul_a_ff <= WORD_W'(time_left_ff);
                        mul_b_ff <= clock_hz_ff;
                        div_d_ff <= US_PER_SEC;
                        step_ff  <= STEP_SYNC_T;
                     end
                  end
               end
            end

            ST_DIFF: begin
               // read the old stamp, then record the new one
               diff_ff <= last_stamp_ff[ch_idx] - now_ff;
               lt_ff   <= (last_stamp_ff[ch_idx] < now_ff);
               last_stamp_ff[ch_idx] <= now_ff;
               seen_ff[ch_idx]       <= 1'b1;
               if (seen_ff[ch_idx] && !level_ff) begin
                  state_ff <= ST_WRAP;
               end else begin
                  state_ff <= ST_OUT;
               end
            end

            ST_WRAP: begin
               st_meas_ff   <= wrap_in;
               st_wvalid_ff <= 1'b1;
               w_ff         <= wrap_in;
               if (pass_mask_ff[ch_ff]) begin
                  out_width_ff[ch_idx] <= wrap_in;
                  state_ff <= ST_MATCH;
               end else begin
                  state_ff <= ST_OUT;
               end
            end

            ST_MATCH: begin
               st_match_ff  <= match_in;
               st_mvalid_ff <= 1'b1;
               state_ff     <= ST_OUT;
            end

            ST_MUL: begin
               acc_ff   <= acc_in;
               mul_a_ff <= {mul_a_ff[WORD_W-2:0], 1'b0};
               if (cnt_ff == '0) begin
                  cnt_ff   <= CNT_W'(PROD_W - 1);
                  state_ff <= ST_DIV;
               end else begin
                  cnt_ff <= cnt_ff - CNT_W'(1);
               end
            end

            ST_DIV: begin
               acc_ff <= {acc_ff[PROD_W-2:0], 1'b0};
               rem_ff <= rem_in;
               quo_ff <= {quo_ff[WORD_W-2:0], qbit};
               ovf_ff <= ovf_ff | quo_ff[WORD_W-1];
               if (cnt_ff == '0) begin
                  state_ff <= ST_POST;
               end else begin
                  cnt_ff <= cnt_ff - CNT_W'(1);
               end
            end

            ST_POST: begin
               // default: chain another conversion
               acc_ff   <= '0;
               rem_ff   <= '0;
               quo_ff   <= '0;
               ovf_ff   <= 1'b0;
               cnt_ff   <= CNT_W'(WORD_W - 1);
               state_ff <= ST_MUL;
               case (step_ff)
                  STEP_START_T: begin
                     st_ppm_t_ff  <= conv_res;
                     st_pin_ff    <= 1'b0;
                     time_left_ff <= (time_left_ff > FRAME_W'(start_us_ff)) ?
                                     time_left_ff - FRAME_W'(start_us_ff) : '0;
                     in_slot_ff   <= 1'b1;
                     state_ff     <= ST_OUT;
                  end
                  STEP_SLOT_US: begin
                     mul_a_ff <= WORD_W'(clamp_us);
                     mul_b_ff <= clock_hz_ff;
                     div_d_ff <= US_PER_SEC;
                     step_ff  <= STEP_SLOT_T;
                  end
                  STEP_SLOT_T: begin
                     st_ppm_t_ff <= conv_res;
                     mul_a_ff    <= conv_res;
                     mul_b_ff    <= US_PER_SEC;
                     div_d_ff    <= clk_div;
                     step_ff     <= STEP_SLOT_US2;
                  end
                  STEP_SLOT_US2: begin
                     time_left_ff <= (conv_res >= WORD_W'(time_left_ff)) ?
                                     '0 : time_left_ff - conv_res[FRAME_W-1:0];
                     slot_idx_ff  <= slot_idx_ff + SLOT_W'(1);
                     in_slot_ff   <= 1'b0;
                     st_pin_ff    <= 1'b1;
                     state_ff     <= ST_OUT;
                  end
                  STEP_SYNC_T: begin
                     st_ppm_t_ff  <= conv_res;
                     time_left_ff <= frame_us_ff;
                     slot_idx_ff  <= '0;
                     in_slot_ff   <= 1'b0;
                     st_pin_ff    <= 1'b1;
                     state_ff     <= ST_OUT;
                  end
                  default: state_ff <= ST_OUT;
               endcase
            end

            ST_OUT: begin
               // hold the staged result until the output register frees up
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_meas_ff   <= st_meas_ff;
                  rsp_wvalid_ff <= st_wvalid_ff;
                  rsp_match_ff  <= st_match_ff;
                  rsp_mvalid_ff <= st_mvalid_ff;
                  rsp_ppm_t_ff  <= st_ppm_t_ff;
                  rsp_pin_ff    <= st_pin_ff;
                  state_ff      <= ST_IDLE;
               end
            end

            default: state_ff <= ST_IDLE;
         endcase

         // a set or capture on a bad channel never reaches here with ch_ok low
         if (state_ff == ST_DIFF && !ch_ok) begin
            state_ff <= ST_OUT;
         end
      end
   end

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Testbench for the RC PWM capture to PPM encoder: capture widths, software sets
// and PPM frame stepping checked against an in-bench scoreboard.
// Depends on rcppm_pkg, rcppm_req_if, rcppm_rsp_if and the top level.
`default_nettype none

module tb_top;
   import rcppm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NCH = NUM_CHANNELS_DEF;

   typedef struct packed {
      logic [WORD_W-1:0] measured_width;
      logic              width_valid;
      logic [WORD_W-1:0] match_value;
      logic              match_valid;
      logic [WORD_W-1:0] ppm_interval_tics;
      logic              ppm_pin_level;
   } encoder_result_t;

   // Scoreboard: mirrors the block's registers and state, queues expected results.
   class encoder_scoreboard;
      logic [CLK_W-1:0]   clk_hz;
      logic [WORD_W-1:0]  cap_per;
      logic [WORD_W-1:0]  pwm_per;
      logic [FRAME_W-1:0] frame_us;
      logic [START_W-1:0] start_us;
      logic [MASK_W-1:0]  pass_mask;
      logic [WORD_W-1:0]  stamp [NCH];
      bit                 seen [NCH];
      logic [WORD_W-1:0]  out_w [NCH];
      bit                 in_slot;
      int unsigned        slot_idx;
      logic [WORD_W-1:0]  left_us;
      encoder_result_t    pending [$];
      int                 errors;
      int                 checked;

      function void clear();
         clk_hz = RST_CLOCK_HZ; cap_per = RST_CAPTURE_PER; pwm_per = RST_PWM_PER;
         frame_us = RST_PPM_FRAME; start_us = RST_PPM_START; pass_mask = RST_PASS_MASK;
         foreach (seen[i]) begin
            seen[i] = 0; out_w[i] = '0; stamp[i] = '0;
         end
         in_slot = 0; slot_idx = 0; left_us = RST_PPM_FRAME;
         errors = 0; checked = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [WORD_W-1:0] v);
         case (idx)
            REG_CLOCK_HZ:    clk_hz = v[CLK_W-1:0];
            REG_CAPTURE_PER: cap_per = v;
            REG_PWM_PER:     pwm_per = v;
            REG_PPM_FRAME:   frame_us = v[FRAME_W-1:0];
            REG_PPM_START:   start_us = v[START_W-1:0];
            REG_PASS_MASK:   pass_mask = v[MASK_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [WORD_W-1:0] sat(logic [63:0] v);
         return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
      endfunction

      function logic [WORD_W-1:0] us2tics(logic [WORD_W-1:0] us);
         logic [63:0] p;
         p = 64'(us) * 64'(clk_hz);
         return sat(p / 64'd1000000);
      endfunction

      function logic [WORD_W-1:0] tics2us(logic [WORD_W-1:0] t);
         logic [63:0] p;
         logic [63:0] d;
         p = 64'(t) * 64'd1000000;
         d = (clk_hz == 0) ? 64'd1 : 64'(clk_hz);
         return sat(p / d);
      endfunction

      function logic [WORD_W-1:0] match_of(logic [WORD_W-1:0] w);
         if (w > pwm_per) return '0;
         if (w == 0) return (pwm_per != 0) ? pwm_per - 1 : '0;
         return pwm_per - w;
      endfunction

      function logic [WORD_W-1:0] slot_len(logic [WORD_W-1:0] w);
         logic [WORD_W-1:0] us;
         logic [WORD_W-1:0] p;
         us = tics2us(w);
         if (us < 1000) p = 700;
         else if (us > 2000) p = 1700;
         else p = us - 300;
         return us2tics(p);
      endfunction

      function logic [WORD_W-1:0] less_sat(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
         return (a > b) ? a - b : '0;
      endfunction

      // Note one accepted request and queue the result it must produce.
      function void note_request(logic [CMD_W-1:0] cmd, logic [CH_W-1:0] ch,
                                 logic [WORD_W-1:0] now, logic lvl,
                                 logic [WORD_W-1:0] wset);
         encoder_result_t r;
         logic [WORD_W-1:0] d;
         logic [WORD_W-1:0] t;
         r = '0;
         if (cmd == CMD_CAPTURE && ch < NCH) begin
            if (seen[ch] && !lvl) begin
               d = (stamp[ch] < now) ? stamp[ch] + cap_per - now : stamp[ch] - now;
               r.measured_width = d; r.width_valid = 1;
               if (pass_mask[ch]) begin
                  out_w[ch] = d; r.match_value = match_of(d); r.match_valid = 1;
               end
            end
            stamp[ch] = now; seen[ch] = 1;
         end else if (cmd == CMD_SET && ch < NCH) begin
            out_w[ch] = wset;
            r.measured_width = wset; r.width_valid = 1;
            r.match_value = match_of(wset); r.match_valid = 1;
         end else if (cmd == CMD_PPM) begin
            if (!in_slot) begin
               t = us2tics(32'(start_us));
               left_us = less_sat(left_us, 32'(start_us));
               r.ppm_pin_level = 0; in_slot = 1;
            end else begin
               if (slot_idx < NCH) begin
                  t = slot_len(out_w[NCH-1-slot_idx]);
                  left_us = less_sat(left_us, tics2us(t));
                  slot_idx++;
               end else begin
                  t = us2tics(left_us);
                  left_us = 32'(frame_us); slot_idx = 0;
               end
               r.ppm_pin_level = 1; in_slot = 0;
            end
            r.ppm_interval_tics = t;
         end
         pending.push_back(r);
      endfunction

      // Compare one transferred result with the oldest expectation.
      function void check_result(encoder_result_t got);
         encoder_result_t e;
         if (pending.size() == 0) begin
            $error("result with nothing expected");
            errors++;
            return;
         end
         e = pending.pop_front();
         checked++;
         if (got.measured_width !== e.measured_width) begin
            $error("measured_width expected %0d got %0d", e.measured_width, got.measured_width);
            errors++;
         end
         if (got.width_valid !== e.width_valid) begin
            $error("width_valid expected %0d got %0d", e.width_valid, got.width_valid);
            errors++;
         end
         if (got.match_value !== e.match_value) begin
            $error("match_value expected %0d got %0d", e.match_value, got.match_value);
            errors++;
         end
         if (got.match_valid !== e.match_valid) begin
            $error("match_valid expected %0d got %0d", e.match_valid, got.match_valid);
            errors++;
         end
         if (got.ppm_interval_tics !== e.ppm_interval_tics) begin
            $error("ppm_interval_tics expected %0d got %0d",
                   e.ppm_interval_tics, got.ppm_interval_tics);
            errors++;
         end
         if (got.ppm_pin_level !== e.ppm_pin_level) begin
            $error("ppm_pin_level expected %0d got %0d", e.ppm_pin_level, got.ppm_pin_level);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic                 csr_we = 0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [WORD_W-1:0]    csr_data = '0;

   rcppm_req_if req ();
   rcppm_rsp_if rsp ();

   rc_pwm_capture_to_ppm_encoder dut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_we(csr_we), .csr_index(csr_index), .csr_data(csr_data)
   );

   encoder_scoreboard sb = new();

   // Knobs shared by the driver and the receiver.
   bit quiet_mode = 0;     // no idling on either side
   int hold_off = 0;       // receiver holds ready low this many cycles
   int sent = 0;
   int ppm_ticks = 0;

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      req.valid = 0; req.command = '0; req.channel = '0; req.timestamp = '0;
      req.pin_level = 0; req.width_tics = '0;
      rsp.ready = 0;
   end

   // Receiver: random ready with an optional long hold-off, counted in cycles.
   initial begin
      @(posedge clock);
      forever begin
         @(posedge clock);
         if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            rsp.ready <= 0;
         end else begin
            rsp.ready <= quiet_mode ? 1'b1 : ($urandom_range(99) >= 19);
         end
      end
   end

   // Monitor: check every result transfer.
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready)
         sb.check_result('{rsp.measured_width, rsp.width_valid, rsp.match_value,
                           rsp.match_valid, rsp.ppm_interval_tics, rsp.ppm_pin_level});
   end

   // Offer one request and hold it until transferred; random gaps first.
   // Valid stays up after the transfer; the next gap or the caller drops it.
   task automatic send_item(logic [CMD_W-1:0] cmd, logic [CH_W-1:0] ch,
                            logic [WORD_W-1:0] ts, logic lvl, logic [WORD_W-1:0] w);
      while (!quiet_mode && $urandom_range(99) < 19) begin
         req.valid <= 0;
         @(posedge clock);
      end
      req.valid <= 1; req.command <= cmd; req.channel <= ch;
      req.timestamp <= ts; req.pin_level <= lvl; req.width_tics <= w;
      do @(posedge clock); while (!req.ready);
      sb.note_request(cmd, ch, ts, lvl, w);
      sent++;
      if (cmd == CMD_PPM) ppm_ticks++;
   endtask

   // Wait until every expectation has been met, then let the block settle.
   task automatic drain();
      int n;
      req.valid <= 0;
      n = 0;
      while (sb.pending.size() != 0) @(posedge clock);
      while (n < 400) begin
         @(posedge clock);
         n++;
      end
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [WORD_W-1:0] v);
      csr_we <= 1; csr_index <= idx; csr_data <= v;
      @(posedge clock);
      sb.write_reg(idx, v);
      csr_we <= 0;
   endtask

   function automatic logic [WORD_W-1:0] rand_word();
      case ($urandom_range(5))
         0: return '0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom_range(200000, 80000);
         default: return $urandom();
      endcase
   endfunction

   // A rising then falling edge pair on one channel: a well-formed pulse.
   task automatic send_pulse(logic [CH_W-1:0] ch);
      logic [WORD_W-1:0] t0;
      logic [WORD_W-1:0] wd;
      t0 = rand_word();
      wd = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(200000, 60000);
      send_item(CMD_CAPTURE, ch, t0, 1'b1, '0);
      send_item(CMD_CAPTURE, ch, t0 - wd, 1'b0, $urandom());
   endtask

   task automatic random_phase(int count);
      int k;
      int sel;
      k = 0;
      while (k < count) begin
         sel = $urandom_range(99);
         if (sel < 40) begin
            send_pulse(CH_W'($urandom_range(NCH-1)));
            k += 2;
         end else if (sel < 70) begin
            send_item(CMD_PPM, CH_W'($urandom()), $urandom(), 1'($urandom()), $urandom());
            k++;
         end else if (sel < 85) begin
            send_item(CMD_SET, CH_W'($urandom()), $urandom(), 1'($urandom()), rand_word());
            k++;
         end else begin
            send_item(CMD_W'($urandom_range(3)), CH_W'($urandom()), rand_word(),
                      1'($urandom()), $urandom());
            k++;
         end
      end
   endtask

   initial begin
      int i;
      sb.clear();
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: first edge only records, rising edge reports nothing.
      send_item(CMD_CAPTURE, 0, 32'd1000, 0, '0);
      send_item(CMD_CAPTURE, 0, 32'd500, 1, '0);
      send_item(CMD_CAPTURE, 0, 32'd100, 0, '0);
      // Wrap: last stamp below the current one.
      send_item(CMD_CAPTURE, 0, 32'hFFFF_FFFF, 0, '0);
      send_item(CMD_CAPTURE, 0, 32'd0, 0, '0);
      // Width above the period, width zero, and the extremes of a set.
      send_item(CMD_SET, 1, '0, 0, 32'hFFFF_FFFF);
      send_item(CMD_SET, 2, '0, 0, '0);
      send_item(CMD_SET, 3, '0, 0, 32'd120000);
      send_item(CMD_SET, 7, 32'hFFFF_FFFF, 1, 32'd1600000);
      // Unused command.
      send_item(2'd3, 7, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF);
      // A whole PPM frame: start pulses, channel slots and the sync slot.
      for (i = 0; i < 2 * (NCH + 1) + 1; i++)
         send_item(CMD_PPM, '0, '0, 0, '0);
      drain();

      // Settings: extremes, zeros, and random ones in between.
      for (i = 0; i < 6; i++) begin
         case (i)
            0: begin
               write_csr(REG_CLOCK_HZ, 32'd1000000); write_csr(REG_CAPTURE_PER, 32'd1);
               write_csr(REG_PWM_PER, 32'd1); write_csr(REG_PPM_FRAME, 32'd1000);
               write_csr(REG_PPM_START, 32'd1); write_csr(REG_PASS_MASK, 32'd0);
            end
            1: begin
               write_csr(REG_CLOCK_HZ, 32'd120000000);
               write_csr(REG_CAPTURE_PER, 32'hFFFF_FFFF);
               write_csr(REG_PWM_PER, 32'hFFFF_FFFF); write_csr(REG_PPM_FRAME, 32'd100000);
               write_csr(REG_PPM_START, 32'd10000); write_csr(REG_PASS_MASK, 32'd255);
            end
            2: begin
               write_csr(REG_CLOCK_HZ, 32'd0); write_csr(REG_PWM_PER, 32'd0);
               write_csr(REG_PASS_MASK, $urandom_range(255));
            end
            3: begin
               write_csr(REG_CLOCK_HZ, 32'h07FF_FFFF); write_csr(REG_PPM_FRAME, 32'h1FFFF);
               write_csr(REG_PPM_START, 32'h3FFF); write_csr(REG_CAPTURE_PER, 32'd4800000);
            end
            default: begin
               write_csr(REG_CLOCK_HZ, $urandom_range(120000000, 1000000));
               write_csr(REG_CAPTURE_PER, $urandom_range(32'hFFFF_FFFF, 1));
               write_csr(REG_PWM_PER, $urandom_range(3200000, 1));
               write_csr(REG_PPM_FRAME, $urandom_range(100000, 1000));
               write_csr(REG_PPM_START, $urandom_range(10000, 1));
               write_csr(REG_PASS_MASK, $urandom_range(255));
            end
         endcase
         quiet_mode = (i == 4);
         random_phase(170);
         if (i == 1) begin
            // Long receiver stall while requests keep coming.
            hold_off = 600;
            random_phase(12);
         end
         if (i == 3) begin
            // Sender pauses until every result is in.
            req.valid <= 0;
            while (sb.pending.size() != 0) @(posedge clock);
            random_phase(4);
         end
         drain();
      end

      $display("tb_top: %0d items sent, %0d results checked, %0d PPM ticks, 6 settings",
               sent, sb.checked, ppm_ticks);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

   initial begin
      #20ms;
      $display("tb_top: errors");
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
hdl/rcppm_pkg.sv
hdl/rcppm_req_if.sv
hdl/rcppm_rsp_if.sv
hdl/rc_pwm_capture_to_ppm_encoder.sv
bench/tb_top.sv
